// ===== design/sll_pkg.sv =====
`default_nettype none
package sll_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_INIT   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // slot memory read address select
    localparam logic [1:0] RD_CUR  = 2'd0;
    localparam logic [1:0] RD_LINK = 2'd1;
    localparam logic [1:0] RD_FREE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       cap;        // latch input word, start walk registers
        logic       rd_en;      // read slot memories
        logic [1:0] rd_sel;     // read address source
        logic       step;       // advance walk by one link
        logic       hit_cap;    // keep link of the slot found
        logic       sweep;      // write one free-chain link
        logic       ins_lnk;    // hook free slot behind predecessor or at head
        logic       ins_fill;   // write key and link of fresh slot, pop free list
        logic       del_unl;    // unhook found slot
        logic       del_free;   // push found slot on free list
        logic       res_load;   // load output register
        logic [1:0] res_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       full;       // free list empty
        logic       cur_ok;     // walk start slot is valid
        logic       rd_lt;      // slot key below search key
        logic       rd_eq;      // slot key equals search key
        logic       nxt_ok;     // next link valid and step bound not reached
        logic       sweep_last;
        logic       out_free;   // output register can take a word
    } t_sts;

endpackage
`default_nettype wire

// ===== design/sll_ctrl.sv =====
`default_nettype none
module sll_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire sll_pkg::t_sts i_sts,
    output sll_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_SWEEP    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISP     = 4'd2;
    localparam logic [3:0] S_CMP      = 4'd3;
    localparam logic [3:0] S_INS_RD   = 4'd4;
    localparam logic [3:0] S_INS_LNK  = 4'd5;
    localparam logic [3:0] S_INS_FILL = 4'd6;
    localparam logic [3:0] S_DEL_UNL  = 4'd7;
    localparam logic [3:0] S_DEL_FREE = 4'd8;
    localparam logic [3:0] S_RES      = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_res_status, n_res_status;
    logic       r_sweep_res, n_sweep_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_res_status <= sll_pkg::ST_OK;
            r_sweep_res  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            r_sweep_res  <= n_sweep_res;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_sweep_res  = r_sweep_res;
        o_cmd        = '0;
        o_cmd.res_status = r_res_status;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_sweep_res  = 1'b0;
                    n_res_status = sll_pkg::ST_OK;
                    n_state      = r_sweep_res ? S_RES : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op == sll_pkg::OP_INIT) begin
                    n_sweep_res = 1'b1;
                    n_state     = S_SWEEP;
                end else if (i_sts.op != sll_pkg::OP_INSERT &&
                             i_sts.op != sll_pkg::OP_DELETE) begin
                    n_res_status = sll_pkg::ST_OK;
                    n_state      = S_RES;
                end else if (i_sts.op == sll_pkg::OP_INSERT && i_sts.full) begin
                    n_res_status = sll_pkg::ST_FULL;
                    n_state      = S_RES;
                end else if (i_sts.cur_ok) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = sll_pkg::RD_CUR;
                    n_state      = S_CMP;
                end else if (i_sts.op == sll_pkg::OP_INSERT) begin
                    n_state = S_INS_RD;
                end else begin
                    n_res_status = sll_pkg::ST_MISSING;
                    n_state      = S_RES;
                end
            end
            S_CMP: begin
                if (i_sts.rd_lt) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.nxt_ok) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = sll_pkg::RD_LINK;
                    end else if (i_sts.op == sll_pkg::OP_INSERT) begin
                        n_state = S_INS_RD;
                    end else begin
                        n_res_status = sll_pkg::ST_MISSING;
                        n_state      = S_RES;
                    end
                end else begin
                    o_cmd.hit_cap = 1'b1;
                    if (i_sts.op == sll_pkg::OP_INSERT) begin
                        if (i_sts.rd_eq) begin
                            n_res_status = sll_pkg::ST_DUP;
                            n_state      = S_RES;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end else if (i_sts.rd_eq) begin
                        n_state = S_DEL_UNL;
                    end else begin
                        n_res_status = sll_pkg::ST_MISSING;
                        n_state      = S_RES;
                    end
                end
            end
            S_INS_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = sll_pkg::RD_FREE;
                n_state      = S_INS_LNK;
            end
            S_INS_LNK: begin
                o_cmd.ins_lnk = 1'b1;
                n_state       = S_INS_FILL;
            end
            S_INS_FILL: begin
                o_cmd.ins_fill = 1'b1;
                n_res_status   = sll_pkg::ST_OK;
                n_state        = S_RES;
            end
            S_DEL_UNL: begin
                o_cmd.del_unl = 1'b1;
                n_state       = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                o_cmd.del_free = 1'b1;
                n_res_status   = sll_pkg::ST_OK;
                n_state        = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/sll_dpath.sv =====
`default_nettype none
module sll_dpath #(
    parameter int SLOTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [31:0] i_key_value,
    input  wire sll_pkg::t_cmd      i_cmd,
    output sll_pkg::t_sts           o_sts,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic [4:0]              o_entry_count
);

    localparam int AW = $clog2(SLOTS);       // slot index
    localparam int LW = $clog2(SLOTS + 1);   // link, null link = SLOTS
    localparam int EW = (LW > 5) ? LW : 5;
    localparam logic [LW-1:0] INV  = LW'(SLOTS);
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    logic signed [31:0] mem_key  [SLOTS];
    logic [LW-1:0]      mem_link [SLOTS];

    logic [1:0]         r_op;
    logic signed [31:0] r_key;
    logic [LW-1:0]      r_head, r_free, r_cur, r_prev, r_at_link, r_steps;
    logic [LW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic signed [31:0] r_rd_key;
    logic [LW-1:0]      r_rd_link;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [4:0]         r_ecount;

    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [LW-1:0]      wr_data;
    logic [LW:0]        steps_nxt;
    logic [EW-1:0]      count_ext;

    always_comb begin
        case (i_cmd.rd_sel)
            sll_pkg::RD_LINK: rd_addr = r_rd_link[AW-1:0];
            sll_pkg::RD_FREE: rd_addr = r_free[AW-1:0];
            default:          rd_addr = r_cur[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_key  <= mem_key[rd_addr];
            r_rd_link <= mem_link[rd_addr];
        end
    end

    // one link write per cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = (r_idx == '0) ? INV : LW'(r_idx) - LW'(1);
        if (i_cmd.sweep) begin
            wr_en = 1'b1;
        end else if (i_cmd.ins_lnk) begin
            wr_en   = (r_prev != INV);
            wr_addr = r_prev[AW-1:0];
            wr_data = r_free;
        end else if (i_cmd.ins_fill) begin
            wr_en   = 1'b1;
            wr_addr = r_free[AW-1:0];
            wr_data = r_cur;
        end else if (i_cmd.del_unl) begin
            wr_en   = (r_prev != INV);
            wr_addr = r_prev[AW-1:0];
            wr_data = r_at_link;
        end else if (i_cmd.del_free) begin
            wr_en   = 1'b1;
            wr_addr = r_cur[AW-1:0];
            wr_data = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_link[wr_addr] <= wr_data;
        end
        if (i_cmd.ins_fill) begin
            mem_key[r_free[AW-1:0]] <= r_key;
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op    <= i_operation;
            r_key   <= i_key_value;
            r_prev  <= INV;
            r_cur   <= r_head;
            r_steps <= '0;
        end
        if (i_cmd.step) begin
            r_prev  <= r_cur;
            r_cur   <= r_rd_link;
            r_steps <= r_steps + LW'(1);
        end
        if (i_cmd.hit_cap) begin
            r_at_link <= r_rd_link;
        end
    end

    // list control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_head  <= INV;
            r_free  <= LW'(SLOTS - 1);
            r_count <= '0;
        end else begin
            if (i_cmd.sweep) begin
                if (r_idx == LAST) begin
                    r_idx   <= '0;
                    r_head  <= INV;
                    r_free  <= LW'(SLOTS - 1);
                    r_count <= '0;
                end else begin
                    r_idx <= r_idx + AW'(1);
                end
            end
            if (i_cmd.ins_lnk && r_prev == INV) begin
                r_head <= r_free;
            end
            if (i_cmd.ins_fill) begin
                r_free  <= r_rd_link;
                r_count <= r_count + LW'(1);
            end
            if (i_cmd.del_unl && r_prev == INV) begin
                r_head <= r_at_link;
            end
            if (i_cmd.del_free) begin
                r_free <= r_cur;
                if (r_count != '0) begin
                    r_count <= r_count - LW'(1);
                end
            end
        end
    end

    // output register
    assign count_ext = EW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            r_ecount <= count_ext[4:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_ecount;

    assign steps_nxt = {1'b0, r_steps} + (LW + 1)'(1);

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.full       = (r_free >= INV);
        o_sts.cur_ok     = (r_cur < INV);
        o_sts.rd_lt      = (r_rd_key < r_key);
        o_sts.rd_eq      = (r_rd_key == r_key);
        o_sts.nxt_ok     = (r_rd_link < INV) && (steps_nxt < (LW + 1)'(SLOTS));
        o_sts.sweep_last = (r_idx == LAST);
        o_sts.out_free   = !r_out_valid || !i_stall;
    end

endmodule
`default_nettype wire

// ===== design/sorted_static_linked_list.sv =====
// Sequence: an insert walks the chain, then reads, links and fills a free slot; a delete
//   walks, unlinks and frees the slot found; full, duplicate and missing end sooner.
// Throughput: one word at a time, the next taken the cycle after the result is loaded;
//   the walk reads one link a cycle.
// Reinitialize rebuilds the free chain one slot a cycle, then gives its result.
// Reset: synchronous, active low; then the free-chain sweep covers all slots, no word taken.
`default_nettype none
module sorted_static_linked_list #(
    parameter int SLOTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // command channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [31:0] i_key_value,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic [4:0]              o_entry_count
);

    // Controller sequences each word: dispatch, walk the sorted chain with one
    // slot read per cycle (next address comes straight from the read link),
    // then relink in two steps: a link write (head move at the head), then a
    // link write. The datapath owns the key and link memories, head/free pointers,
    // count and output register. The null link is SLOTS; walks are bounded to SLOTS steps.

    sll_pkg::t_cmd cmd;
    sll_pkg::t_sts sts;

    sll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sll_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_operation),
        .i_key_value   (i_key_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule
`default_nettype wire

// ===== design/sll_checker.sv =====
`default_nettype none
module sll_checker #(
    parameter int SLOTS = 16
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [1:0]         o_status,
    input wire logic [4:0]         o_entry_count
);

    // one word in flight: busy right after a command is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("command taken while previous one in flight");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_entry_count)))
        else $error("stalled result changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && SLOTS < 32) |-> (32'(o_entry_count) <= 32'(SLOTS)))
        else $error("entry count above slot count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == sll_pkg::ST_FULL) |-> (o_entry_count == 5'(SLOTS)))
        else $error("full status with free slots left");

endmodule

bind sorted_static_linked_list sll_checker #(
    .SLOTS (SLOTS)
) u_sll_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
`default_nettype wire
